FILE: design/slt_pkg.sv
package slt_pkg;

    // Table size default
    localparam int TRACKED_SOURCES_DEF = 8;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int LOCK_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_SECONDS = 1'd1;

    // Reset values
    localparam logic [COUNT_W-1:0] MAX_FAILURES_RST    = 8'd5;
    localparam logic [LOCK_W-1:0]  LOCKOUT_SECONDS_RST = 16'd300;

    // Command codes
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_LOGIN = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

    // One table entry as kept in RAM; the used flags live in flops
    typedef struct packed {
        logic [ADDR_W-1:0]  key;
        logic [COUNT_W-1:0] failures;
        logic [TIME_W-1:0]  lock_end;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic check;
        logic update;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rd_last;
    } dp_stat_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: design/source_lockout_tracker.sv
// Source lockout tracker: per-address failed-login counting with timed lockout.
// Input: present cmd, source_addr, credentials_ok and now_seconds with start;
// the item is taken at a clock edge where start is high and busy is low.
// Output: done pulses high for one cycle with locked_out, login_ok and
// failure_count valid in that cycle; the receiver must take it then, there
// is no stall on the result side.
// Timing: the table is scanned one entry per cycle through a single RAM read
// port, then the drain, check, update and emit states follow in that order.
// done is high in the same cycle in which busy is low again, and a new item
// is taken only while busy is low, so items do not overlap.
// Configuration: cfg_we, cfg_index and cfg_data write max_failures (index 0)
// or lockout_seconds (index 1). The user must write them only while the block
// is idle; the block itself does not enforce this.
// Reset: rst_n clears all used flags, so the table is empty, and restores
// max_failures to 5 and lockout_seconds to 300. No clearing pass is needed.
module source_lockout_tracker
    import slt_pkg::*;
#(
    parameter int TRACKED_SOURCES = TRACKED_SOURCES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd,
    input  logic [ADDR_W-1:0]     source_addr,
    input  logic                  credentials_ok,
    input  logic [TIME_W-1:0]     now_seconds,
    output logic                  locked_out,
    output logic                  login_ok,
    output logic [COUNT_W-1:0]    failure_count
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    slt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (ctrl_cmd),
        .busy  (busy),
        .done  (done)
    );

    slt_datapath #(
        .TRACKED_SOURCES (TRACKED_SOURCES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .stat          (dp_stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_cmd        (cmd),
        .in_addr       (source_addr),
        .in_cred       (credentials_ok),
        .in_now        (now_seconds),
        .locked_out    (locked_out),
        .login_ok      (login_ok),
        .failure_count (failure_count)
    );

    // An accepted item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // The result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Result comes out as the controller returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    // An accepted login never leaves the source locked
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && login_ok) |-> !locked_out)
        else $error("accepted login reported locked");

endmodule

FILE: design/slt_ram.sv
module slt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/slt_ctrl.sv
module slt_ctrl
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CHECK,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: design/slt_datapath.sv
module slt_datapath
    import slt_pkg::*;
#(
    parameter int TRACKED_SOURCES = TRACKED_SOURCES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_cmd,
    input  logic [ADDR_W-1:0]     in_addr,
    input  logic                  in_cred,
    input  logic [TIME_W-1:0]     in_now,
    output logic                  locked_out,
    output logic                  login_ok,
    output logic [COUNT_W-1:0]    failure_count
);

    localparam int IDX_W = idx_width(TRACKED_SOURCES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRACKED_SOURCES - 1);

    // Configuration
    logic [COUNT_W-1:0] max_failures_reg;
    logic [LOCK_W-1:0]  lockout_seconds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_failures_reg    <= MAX_FAILURES_RST;
            lockout_seconds_reg <= LOCKOUT_SECONDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_FAILURES:    max_failures_reg    <= cfg_data[COUNT_W-1:0];
                REG_LOCKOUT_SECONDS: lockout_seconds_reg <= cfg_data[LOCK_W-1:0];
                default:             ;
            endcase
        end
    end

    // Captured item
    logic              cmd_reg;
    logic [ADDR_W-1:0] key_reg;
    logic              cred_reg;
    logic [TIME_W-1:0] now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_cmd;
            key_reg  <= in_addr;
            cred_reg <= in_cred;
            now_reg  <= in_now;
        end
    end

    // Entry store: used flags in flops, the rest in RAM
    logic [TRACKED_SOURCES-1:0] used_reg;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    entry_t                     ram_wdata;
    entry_t                     ram_rdata;
    logic [IDX_W-1:0]           rd_idx_reg;

    slt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TRACKED_SOURCES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Scan: read address counter, compare in the cycle after each read
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [COUNT_W-1:0] match_f_reg;
    logic [TIME_W-1:0]  match_e_reg;
    logic             min_valid_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic [TIME_W-1:0] min_e_reg;
    logic             cmp_used;

    assign stat.rd_last = (rd_idx_reg == IDX_LAST);
    assign cmp_used     = used_reg[cmp_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            min_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan;
            if (cmd.capture)
            begin
                rd_idx_reg    <= '0;
                match_reg     <= 1'b0;
                min_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !stat.rd_last)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (cmp_valid_reg)
                begin
                    if (cmp_used && (ram_rdata.key == key_reg) && !match_reg)
                    begin
                        match_reg <= 1'b1;
                    end
                    if (!min_valid_reg || (ram_rdata.lock_end < min_e_reg))
                    begin
                        min_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Scan payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_idx_reg;
        if (cmp_valid_reg)
        begin
            if (cmp_used && (ram_rdata.key == key_reg) && !match_reg)
            begin
                match_idx_reg <= cmp_idx_reg;
                match_f_reg   <= ram_rdata.failures;
                match_e_reg   <= ram_rdata.lock_end;
            end
            if (!min_valid_reg || (ram_rdata.lock_end < min_e_reg))
            begin
                min_idx_reg <= cmp_idx_reg;
                min_e_reg   <= ram_rdata.lock_end;
            end
        end
    end

    // Check: expire an ended lockout or flag one still running
    logic               cur_locked_reg;
    logic               dirty_reg;
    logic [COUNT_W-1:0] cur_f_reg;
    logic [TIME_W-1:0]  cur_e_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            cur_f_reg      <= match_f_reg;
            cur_e_reg      <= match_e_reg;
            cur_locked_reg <= 1'b0;
            dirty_reg      <= 1'b0;
            if (match_reg && (match_e_reg != '0))
            begin
                if (now_reg >= match_e_reg)
                begin
                    cur_f_reg <= '0;
                    cur_e_reg <= '0;
                    dirty_reg <= 1'b1;
                end
                else
                begin
                    cur_locked_reg <= 1'b1;
                end
            end
        end
    end

    // First free slot
    logic             free_found;
    logic [IDX_W-1:0] free_idx;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TRACKED_SOURCES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Update: apply the attempt, write the entry back
    logic [TIME_W:0]    end_sum;
    logic [TIME_W-1:0]  end_sat;
    logic               upd_we;
    logic               upd_claim;
    logic               upd_ok;
    logic               upd_valid;
    logic [IDX_W-1:0]   upd_idx;
    logic [COUNT_W-1:0] upd_f;
    logic [COUNT_W-1:0] upd_base_f;
    logic [TIME_W-1:0]  upd_e;
    logic [TIME_W-1:0]  upd_base_e;

    assign end_sum = {1'b0, now_reg} + {{(TIME_W + 1 - LOCK_W){1'b0}}, lockout_seconds_reg};
    assign end_sat = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

    always_comb
    begin
        upd_we     = dirty_reg;
        upd_claim  = 1'b0;
        upd_ok     = 1'b0;
        upd_valid  = match_reg;
        upd_idx    = match_idx_reg;
        upd_f      = cur_f_reg;
        upd_e      = cur_e_reg;
        upd_base_f = match_reg ? cur_f_reg : '0;
        upd_base_e = match_reg ? cur_e_reg : '0;
        if ((cmd_reg == CMD_LOGIN) && !cur_locked_reg)
        begin
            if (cred_reg)
            begin
                upd_ok = 1'b1;
                if (match_reg)
                begin
                    upd_f  = '0;
                    upd_e  = '0;
                    upd_we = 1'b1;
                end
            end
            else
            begin
                if (!match_reg)
                begin
                    upd_claim = 1'b1;
                    upd_idx   = free_found ? free_idx : min_idx_reg;
                end
                upd_valid = 1'b1;
                upd_we    = 1'b1;
                upd_f     = (upd_base_f == COUNT_MAX) ? COUNT_MAX : upd_base_f + 1'b1;
                upd_e     = (upd_f >= max_failures_reg) ? end_sat : upd_base_e;
            end
        end
    end

    assign ram_we    = cmd.update && upd_we;
    assign ram_waddr = upd_idx;
    assign ram_wdata = '{key: key_reg, failures: upd_f, lock_end: upd_e};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.update && upd_claim)
        begin
            used_reg[upd_idx] <= 1'b1;
        end
    end

    // Final entry state for the result
    logic               fin_valid_reg;
    logic               fin_ok_reg;
    logic [COUNT_W-1:0] fin_f_reg;
    logic [TIME_W-1:0]  fin_e_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            fin_valid_reg <= upd_valid;
            fin_ok_reg    <= upd_ok;
            fin_f_reg     <= upd_f;
            fin_e_reg     <= upd_e;
        end
    end

    // Result registers
    logic               locked_out_reg;
    logic               login_ok_reg;
    logic [COUNT_W-1:0] failure_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            locked_out_reg    <= fin_valid_reg && (fin_e_reg != '0) && (now_reg < fin_e_reg);
            login_ok_reg      <= fin_ok_reg;
            failure_count_reg <= fin_valid_reg ? fin_f_reg : '0;
        end
    end

    assign locked_out    = locked_out_reg;
    assign login_ok      = login_ok_reg;
    assign failure_count = failure_count_reg;

endmodule
